// File: hdl/prs80_pkg.sv
package prs80_pkg;

   localparam int BLOCK_W = 64;
   localparam int KEY_W   = 80;
   localparam int RND_W   = 5;
   localparam logic [RND_W-1:0] LAST_ROUND = 5'd31;

   typedef enum logic [1:0] {
      CSR_KEY_LOW  = 2'd0,
      CSR_KEY_HIGH = 2'd1,
      CSR_IV       = 2'd2
   } csr_index_type;

   localparam logic [3:0] SBOX_FWD [16] = '{
      4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
      4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };
   localparam logic [3:0] SBOX_INV [16] = '{
      4'h5, 4'he, 4'hf, 4'h8, 4'hc, 4'h1, 4'h2, 4'hd,
      4'hb, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'ha
   };

   function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] y;
      y = '0;
      for (int n = 0; n < 16; n++) begin
         y[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
      end
      return y;
   endfunction

   function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] y;
      y = '0;
      for (int n = 0; n < 16; n++) begin
         y[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
      end
      return y;
   endfunction

   // bit i goes to 16*i mod 63, a 6-bit rotate left by 4
   function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] y;
      logic [5:0]         j;
      y = '0;
      for (int i = 0; i < BLOCK_W; i++) begin
         j = 6'(i);
         y[{j[1:0], j[5:2]}] = x[i];
      end
      return y;
   endfunction

   // bit i goes to 4*i mod 63, a 6-bit rotate left by 2
   function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] x);
      logic [BLOCK_W-1:0] y;
      logic [5:0]         j;
      y = '0;
      for (int i = 0; i < BLOCK_W; i++) begin
         j = 6'(i);
         y[{j[3:0], j[5:4]}] = x[i];
      end
      return y;
   endfunction

   function automatic logic [KEY_W-1:0] key_fwd(input logic [KEY_W-1:0] k,
                                                input logic [RND_W-1:0] r);
      logic [KEY_W-1:0] t;
      t = {k[18:0], k[79:19]};
      t[79:76] = SBOX_FWD[t[79:76]];
      t[19:15] = t[19:15] ^ r;
      return t;
   endfunction

   function automatic logic [KEY_W-1:0] key_inv(input logic [KEY_W-1:0] k,
                                                input logic [RND_W-1:0] r);
      logic [KEY_W-1:0] t;
      t = k;
      t[19:15] = t[19:15] ^ r;
      t[79:76] = SBOX_INV[t[79:76]];
      return {t[60:0], t[79:61]};
   endfunction

endpackage

// File: hdl/present80_cbc_cipher.sv
// an encrypt runs 31 rounds after the input transfer, one per cycle in the shared
// round unit, then a final key add into the output register once the output slot
// is free; a decrypt runs the rounds in reverse from the cached last round key, or
// after a key write first runs a forward key sweep to rebuild that key; one block in
// flight, the next block is accepted the cycle after the result loads
// synchronous active-high reset clears key, iv, chain register and all control state
module present80_cbc_cipher
   import prs80_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic               req_first_block,
   input  logic [BLOCK_W-1:0] req_data_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BLOCK_W-1:0] rsp_data_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [BLOCK_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KSWEEP,
      ST_ROUND,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   logic [RND_W-1:0]   rnd_ff;
   logic               cmd_ff;
   logic [BLOCK_W-1:0] x_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [BLOCK_W-1:0] chain_ff;
   logic [BLOCK_W-1:0] din_ff;
   logic [15:0]        key_low_ff;
   logic [BLOCK_W-1:0] key_high_ff;
   logic [BLOCK_W-1:0] iv_ff;
   logic [KEY_W-1:0]   key_last_ff;
   logic               last_ok_ff;
   logic               rsp_valid_ff;
   logic [BLOCK_W-1:0] rsp_data_ff;

   logic               unit_dec;
   logic [BLOCK_W-1:0] x_in;
   logic [KEY_W-1:0]   key_in;
   logic               req_xfer;
   logic               csr_xfer;
   logic               slot_free;
   logic [BLOCK_W-1:0] chain_sel;
   logic [BLOCK_W-1:0] result;

   assign req_stall    = (state_ff != ST_IDLE);
   assign csr_ready    = (state_ff == ST_IDLE);
   assign req_xfer     = req_valid && !req_stall;
   assign csr_xfer     = csr_valid && csr_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign chain_sel    = req_first_block ? iv_ff : chain_ff;
   assign unit_dec     = cmd_ff && (state_ff == ST_ROUND);

   always_comb begin
      if (cmd_ff) begin
         result = x_ff ^ key_ff[KEY_W-1 -: BLOCK_W] ^ chain_ff;
      end else begin
         result = x_ff ^ key_ff[KEY_W-1 -: BLOCK_W];
      end
   end

   prs80_round u_round (
      .decrypt (unit_dec),
      .x_in    (x_ff),
      .key_in  (key_ff),
      .rnd     (rnd_ff),
      .x_out   (x_in),
      .key_out (key_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         cmd_ff       <= 1'b0;
         chain_ff     <= '0;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         iv_ff        <= '0;
         last_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_xfer) begin
            unique case (csr_index)
               CSR_KEY_LOW: begin
                  key_low_ff <= csr_wdata[15:0];
                  last_ok_ff <= 1'b0;
               end
               CSR_KEY_HIGH: begin
                  key_high_ff <= csr_wdata;
                  last_ok_ff  <= 1'b0;
               end
               CSR_IV: begin
                  iv_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  cmd_ff   <= req_command;
                  chain_ff <= chain_sel;
                  din_ff   <= req_data_in;
                  if (req_command) begin
                     x_ff <= req_data_in;
                     if (last_ok_ff) begin
                        key_ff   <= key_last_ff;
                        rnd_ff   <= LAST_ROUND;
                        state_ff <= ST_ROUND;
                     end else begin
                        key_ff   <= {key_high_ff, key_low_ff};
                        rnd_ff   <= 5'd1;
                        state_ff <= ST_KSWEEP;
                     end
                  end else begin
                     x_ff     <= req_data_in ^ chain_sel;
                     key_ff   <= {key_high_ff, key_low_ff};
                     rnd_ff   <= 5'd1;
                     state_ff <= ST_ROUND;
                  end
               end
            end
            ST_KSWEEP: begin
               key_ff <= key_in;
               if (rnd_ff == LAST_ROUND) begin
                  key_last_ff <= key_in;
                  last_ok_ff  <= 1'b1;
                  state_ff    <= ST_ROUND;
               end else begin
                  rnd_ff <= rnd_ff + 5'd1;
               end
            end
            ST_ROUND: begin
               x_ff   <= x_in;
               key_ff <= key_in;
               if (cmd_ff) begin
                  if (rnd_ff == 5'd1) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     rnd_ff <= rnd_ff - 5'd1;
                  end
               end else begin
                  if (rnd_ff == LAST_ROUND) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     rnd_ff <= rnd_ff + 5'd1;
                  end
               end
            end
            ST_FINISH: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= result;
                  chain_ff     <= cmd_ff ? din_ff : result;
                  if (!cmd_ff) begin
                     key_last_ff <= key_ff;
                     last_ok_ff  <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: hdl/prs80_round.sv
module prs80_round
   import prs80_pkg::*;
(
   input  logic               decrypt,
   input  logic [BLOCK_W-1:0] x_in,
   input  logic [KEY_W-1:0]   key_in,
   input  logic [RND_W-1:0]   rnd,
   output logic [BLOCK_W-1:0] x_out,
   output logic [KEY_W-1:0]   key_out
);

   logic [BLOCK_W-1:0] mixed;

   assign mixed = x_in ^ key_in[KEY_W-1 -: BLOCK_W];

   always_comb begin
      if (decrypt) begin
         x_out   = sub_inv(perm_inv(mixed));
         key_out = key_inv(key_in, rnd);
      end else begin
         x_out   = perm_fwd(sub_fwd(mixed));
         key_out = key_fwd(key_in, rnd);
      end
   end

endmodule

// File: hdl/prs80_chk.sv
module prs80_chk
   import prs80_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [BLOCK_W-1:0] rsp_data_out,
   input logic               csr_ready
);

   // one block in flight: busy right after an input transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a block was in flight");

   // a fresh result appears only as the block goes idle
   a_rsp_at_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result raised while block still busy");

   // no csr write while a block is processed
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !csr_ready)
      else $error("csr ready while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out))
      else $error("stalled result changed");

endmodule

bind present80_cbc_cipher prs80_chk u_prs80_chk (.*);
